FILE: src/dsx_pkg.sv
// dsx_pkg: shared types, constants and helper functions of the decimal seed
// entry and xorshift unit. No dependencies.
`default_nettype none

package dsx_pkg;

   // operation codes carried by the request transaction
   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_MOVE   = 2'd1;
   localparam logic [1:0] OP_ADJUST = 2'd2;
   localparam logic [1:0] OP_NEXT   = 2'd3;

   localparam logic [31:0] GOLDEN      = 32'h9E37_79B9;
   localparam int          DIGIT_SLOTS = 10;
   localparam int          ROW_W       = 4 * DIGIT_SLOTS;
   // two double-dabble steps per cycle over 32 bits
   localparam logic [3:0]  CONV_LAST   = 4'd15;
   // restoring reduction runs from modulus<<8 down to modulus<<0
   localparam logic [3:0]  MOD_TOP     = 4'd8;
   localparam int          MOD_W       = 12;
   localparam logic [MOD_W-1:0] RADIX  = 12'd10;

   typedef logic [DIGIT_SLOTS-1:0][3:0] digit_row_type;

   typedef struct packed {
      logic       load;
      logic       conv_init;
      logic       conv_step;
      logic       conv_last;
      logic       mod_init;
      logic       mod_step;
      logic       mod_last;
      logic       xs_step;
      logic       val_init;
      logic       val_step;
      logic       out_load;
      logic [3:0] step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       out_free;
   } status_type;

   function automatic logic [31:0] xs32(input logic [31:0] v);
      logic [31:0] t;
      begin
         t = v ^ (v << 13);
         t = t ^ (t >> 17);
         t = t ^ (t << 5);
         return t;
      end
   endfunction

   function automatic logic [31:0] nonzero(input logic [31:0] v);
      return (v == 32'd0) ? 32'd1 : v;
   endfunction

   // one double-dabble step: adjust every bcd digit, then shift in one binary bit
   function automatic logic [ROW_W+31:0] dabble(input logic [ROW_W-1:0] bcd,
                                                input logic [31:0] bin);
      logic [ROW_W-1:0] adj;
      logic [ROW_W+31:0] both;
      begin
         adj = bcd;
         for (int j = 0; j < DIGIT_SLOTS; j++) begin
            if (bcd[4*j +: 4] >= 4'd5) begin
               adj[4*j +: 4] = bcd[4*j +: 4] + 4'd3;
            end
         end
         both = {adj, bin};
         return both << 1;
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/dsx_if.sv
// dsx channel interfaces: request, response and start-seed write channels.
// Depends on nothing but the payload widths of the unit.
`default_nettype none

interface dsx_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic signed [7:0] delta;
   logic [31:0]       entropy;

   modport source (output valid, output opcode, output delta, output entropy, input ready);
   modport sink (input valid, input opcode, input delta, input entropy, output ready);
endinterface

interface dsx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] auto_seed;
   logic [31:0] manual_value;
   logic [39:0] digit_row;
   logic [3:0]  cursor_position;

   modport source (output valid, output auto_seed, output manual_value, output digit_row,
                   output cursor_position, input ready);
   modport sink (input valid, input auto_seed, input manual_value, input digit_row,
                 input cursor_position, output ready);
endinterface

interface dsx_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_seed;

   modport source (output valid, output start_seed, input ready);
   modport sink (input valid, input start_seed, output ready);
endinterface

`default_nettype wire

FILE: src/dsx_ctrl.sv
// dsx_ctrl: sequencing state machine of the seed unit.
// Depends on dsx_pkg for command and status types and operation codes.
`default_nettype none

module dsx_ctrl
   import dsx_pkg::*;
#(
   parameter int DIGITS = 10
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DISP  = 3'd1;
   localparam logic [2:0] ST_CONV  = 3'd2;
   localparam logic [2:0] ST_MODR  = 3'd3;
   localparam logic [2:0] ST_VINIT = 3'd4;
   localparam logic [2:0] ST_VAL   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   localparam logic [3:0] VAL_LAST = 4'(DIGITS - 1);

   logic [2:0] state_ff, state_in;
   logic [3:0] count_ff, count_in;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      cmd.step  = count_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            case (status.op)
               OP_BEGIN: begin
                  cmd.conv_init = 1'b1;
                  count_in      = '0;
                  state_in      = ST_CONV;
               end
               OP_MOVE, OP_ADJUST: begin
                  cmd.mod_init = 1'b1;
                  count_in     = MOD_TOP;
                  state_in     = ST_MODR;
               end
               default: begin
                  cmd.xs_step = 1'b1;
                  state_in    = ST_VINIT;
               end
            endcase
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            count_in      = count_ff + 4'd1;
            if (count_ff == CONV_LAST) begin
               cmd.conv_last = 1'b1;
               state_in      = ST_VINIT;
            end
         end
         ST_MODR: begin
            cmd.mod_step = 1'b1;
            count_in     = count_ff - 4'd1;
            if (count_ff == '0) begin
               cmd.mod_last = 1'b1;
               state_in     = ST_VINIT;
            end
         end
         ST_VINIT: begin
            cmd.val_init = 1'b1;
            count_in     = '0;
            state_in     = ST_VAL;
         end
         ST_VAL: begin
            cmd.val_step = 1'b1;
            count_in     = count_ff + 4'd1;
            if (count_ff == VAL_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/dsx_datapath.sv
// dsx_datapath: seed counter, digit row, cursor, serial decimal converters
// and the response register. Depends on dsx_pkg.
`default_nettype none

module dsx_datapath
   import dsx_pkg::*;
#(
   parameter int DIGITS = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [1:0]        req_opcode,
   input  wire logic signed [7:0] req_delta,
   input  wire logic [31:0]       req_entropy,
   input  wire logic              csr_write,
   input  wire logic [31:0]       csr_start_seed,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [31:0]            rsp_auto_seed,
   output logic [31:0]            rsp_manual_value,
   output logic [39:0]            rsp_digit_row,
   output logic [3:0]             rsp_cursor_position
);

   localparam logic [MOD_W-1:0] DIGITS_M    = MOD_W'(DIGITS);
   localparam logic [MOD_W-1:0] CUR_OFFSET  = MOD_W'(128 * DIGITS);
   localparam logic [MOD_W-1:0] DIG_OFFSET  = MOD_W'(1280);
   localparam logic [3:0]       TOP_SLOT    = 4'(DIGITS - 1);
   localparam logic [ROW_W-1:0] ROW_MASK    = (ROW_W'(1) << (4 * DIGITS)) - ROW_W'(1);

   logic [1:0]             op_ff, op_in;
   logic signed [7:0]      delta_ff, delta_in;
   logic [31:0]            entropy_ff, entropy_in;
   logic [31:0]            seed_ff, seed_in;
   digit_row_type          digits_ff, digits_in;
   logic [3:0]             cursor_ff, cursor_in;
   logic [31:0]            bin_ff, bin_in;
   logic [ROW_W-1:0]       bcd_ff, bcd_in;
   logic [MOD_W-1:0]       mod_ff, mod_in;
   logic [31:0]            acc_ff, acc_in;
   logic [ROW_W-1:0]       scan_ff, scan_in;
   logic [31:0]            auto_ff, auto_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            out_auto_ff, out_auto_in;
   logic [31:0]            out_manual_ff, out_manual_in;
   logic [39:0]            out_row_ff, out_row_in;
   logic [3:0]             out_cursor_ff, out_cursor_in;

   logic [3:0]             slot;
   logic [ROW_W+31:0]      dab1, dab2;
   logic [MOD_W-1:0]       modulus, offset, base, trial, reduced;
   logic [31:0]            seed_next;
   logic [3:0]             digit_top;

   // the cursor counts from the left, nibble slots from the least significant digit
   assign slot      = TOP_SLOT - cursor_ff;
   assign dab1      = dabble(bcd_ff, bin_ff);
   assign dab2      = dabble(dab1[ROW_W+31:32], dab1[31:0]);
   assign modulus   = (op_ff == OP_MOVE) ? DIGITS_M : RADIX;
   assign offset    = (op_ff == OP_MOVE) ? CUR_OFFSET : DIG_OFFSET;
   assign base      = (op_ff == OP_MOVE) ? MOD_W'(cursor_ff) : MOD_W'(digits_ff[slot]);
   assign trial     = modulus << cmd.step;
   assign reduced   = (mod_ff >= trial) ? (mod_ff - trial) : mod_ff;
   assign seed_next = xs32(seed_ff);
   assign digit_top = scan_ff[4*DIGITS-1 -: 4];

   always_comb begin
      op_in         = op_ff;
      delta_in      = delta_ff;
      entropy_in    = entropy_ff;
      seed_in       = seed_ff;
      digits_in     = digits_ff;
      cursor_in     = cursor_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      mod_in        = mod_ff;
      acc_in        = acc_ff;
      scan_in       = scan_ff;
      auto_in       = auto_ff;
      out_auto_in   = out_auto_ff;
      out_manual_in = out_manual_ff;
      out_row_in    = out_row_ff;
      out_cursor_in = out_cursor_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (cmd.load) begin
         op_in      = req_opcode;
         delta_in   = req_delta;
         entropy_in = req_entropy;
         auto_in    = '0;
      end
      if (cmd.conv_init) begin
         bin_in = seed_ff;
         bcd_in = '0;
      end
      if (cmd.conv_step) begin
         bin_in = dab2[31:0];
         bcd_in = dab2[ROW_W+31:32];
      end
      if (cmd.conv_last) begin
         // keeping the low digits gives the counter modulo 10^DIGITS
         digits_in = digit_row_type'(dab2[ROW_W+31:32] & ROW_MASK);
         cursor_in = '0;
      end
      if (cmd.mod_init) begin
         // offset is a multiple of the modulus and keeps the sum non-negative
         mod_in = base + {{(MOD_W-8){delta_ff[7]}}, delta_ff} + offset;
      end
      if (cmd.mod_step) begin
         mod_in = reduced;
      end
      if (cmd.mod_last) begin
         if (op_ff == OP_MOVE) begin
            cursor_in = reduced[3:0];
         end else begin
            digits_in[slot] = reduced[3:0];
         end
      end
      if (cmd.xs_step) begin
         seed_in = seed_next;
         auto_in = nonzero(seed_next ^ {entropy_ff[30:0], 1'b0} ^ GOLDEN);
      end
      if (cmd.val_init) begin
         acc_in  = '0;
         scan_in = digits_ff;
      end
      if (cmd.val_step) begin
         acc_in  = (acc_ff << 3) + (acc_ff << 1) + {28'd0, digit_top};
         scan_in = scan_ff << 4;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         out_auto_in   = auto_ff;
         out_manual_in = nonzero(acc_ff);
         out_row_in    = 40'(digits_ff);
         out_cursor_in = cursor_ff;
      end

      if (csr_write) begin
         seed_in = csr_start_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= 32'd1;
         digits_ff    <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         digits_ff    <= digits_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      delta_ff      <= delta_in;
      entropy_ff    <= entropy_in;
      bin_ff        <= bin_in;
      bcd_ff        <= bcd_in;
      mod_ff        <= mod_in;
      acc_ff        <= acc_in;
      scan_ff       <= scan_in;
      auto_ff       <= auto_in;
      out_auto_ff   <= out_auto_in;
      out_manual_ff <= out_manual_in;
      out_row_ff    <= out_row_in;
      out_cursor_ff <= out_cursor_in;
   end

   assign status.op       = op_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_auto_seed       = out_auto_ff;
   assign rsp_manual_value    = out_manual_ff;
   assign rsp_digit_row       = out_row_ff;
   assign rsp_cursor_position = out_cursor_ff;

endmodule

`default_nettype wire

FILE: src/decimal_seed_entry_and_xorshift_unit.sv
// decimal_seed_entry_and_xorshift_unit: top level, joins controller and datapath.
// From accept to response valid, begin entry runs the double-dabble conversion,
// move or adjust the compare-subtract reduction and next seed an xorshift update;
// each then scans the digit row into the manual value. One transaction at a time,
// the next taken in the cycle after the response is loaded (which waits for out_free).
// Synchronous active-high reset: seed counter 1, digits and cursor zero.
`default_nettype none

module decimal_seed_entry_and_xorshift_unit
   import dsx_pkg::*;
#(
   parameter int DIGITS = 10
) (
   input wire logic clock,
   input wire logic reset,
   dsx_req_if.sink   req_chan,
   dsx_rsp_if.source rsp_chan,
   dsx_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   dsx_ctrl #(.DIGITS(DIGITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dsx_datapath #(.DIGITS(DIGITS)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_chan.opcode),
      .req_delta           (req_chan.delta),
      .req_entropy         (req_chan.entropy),
      .csr_write           (csr_chan.valid),
      .csr_start_seed      (csr_chan.start_seed),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_auto_seed       (rsp_chan.auto_seed),
      .rsp_manual_value    (rsp_chan.manual_value),
      .rsp_digit_row       (rsp_chan.digit_row),
      .rsp_cursor_position (rsp_chan.cursor_position)
   );

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   // a transaction is taken only once per pass through the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // the response register is never overwritten while it still holds a result
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response overwritten");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.cursor_position < 4'(DIGITS)))
      else $error("cursor out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.manual_value != 32'd0))
      else $error("manual value not normalized");

endmodule

`default_nettype wire
